@@ hdl/bgr_pkg.sv @@
// ----------------------------------------------------------------------------
// bgr_pkg: shared types for the block group reverser
// Controller states and the command and status bundles that join the
// controller to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package bgr_pkg;

  // Width of an element value and of the group size register.
  localparam int unsigned ValueWidth = 32;
  localparam int unsigned SizeWidth  = 5;

  // Register reset value of the group size.
  localparam logic [SizeWidth-1:0] SizeReset = 5'd4;

  typedef enum logic [0:0] {
    ST_FILL  = 1'b0,
    ST_DRAIN = 1'b1
  } bgr_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic write;   // store the accepted item in the group buffer
    logic start;   // the accepted item closes a group: set up the drain
    logic emit;    // load the next result into the output register
  } bgr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic group_done;  // the item on the input would close the group
    logic final_one;   // the next result is the last of the group
    logic out_full;    // the output register holds a result
  } bgr_status_t;

endpackage

`default_nettype wire

@@ hdl/bgr_ctrl.sv @@
// ----------------------------------------------------------------------------
// bgr_ctrl: group reverser controller
// Alternates between filling the group buffer and draining it, and issues
// the datapath commands for each cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bgr_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic                out_stall,
  input  wire bgr_pkg::bgr_status_t status,
  output bgr_pkg::bgr_cmd_t        cmd
);
  import bgr_pkg::*;

  bgr_state_t state;
  bgr_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_FILL;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    cmd        = '0;
    case (state)
      ST_FILL: begin
        in_stall  = 1'b0;
        cmd.write = in_valid;
        cmd.start = in_valid && status.group_done;
        if (cmd.start) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // The output register can take a new result when it is empty or
        // its current result leaves in this cycle.
        cmd.emit = !status.out_full || !out_stall;
        if (cmd.emit && status.final_one) begin
          state_next = ST_FILL;
        end
      end
      default: begin
        state_next = ST_FILL;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ hdl/bgr_datapath.sv @@
// ----------------------------------------------------------------------------
// bgr_datapath: group reverser datapath
// Holds the group size register, the group buffer, the fill count, the drain
// pointer and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bgr_datapath #(
  parameter int unsigned MAX_GROUP = 16
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_we,
  input  wire logic [bgr_pkg::SizeWidth-1:0]      cfg_wdata,
  input  wire logic signed [bgr_pkg::ValueWidth-1:0] item_value,
  input  wire logic                               end_of_list,
  input  wire logic                               out_stall,
  input  wire bgr_pkg::bgr_cmd_t                  cmd,
  output bgr_pkg::bgr_status_t                    status,
  output logic                                    out_valid,
  output logic signed [bgr_pkg::ValueWidth-1:0]   out_value,
  output logic                                    out_last
);
  import bgr_pkg::*;

  localparam int unsigned CntWidth = $clog2(MAX_GROUP + 1);
  localparam int unsigned IdxWidth = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;

  logic [SizeWidth-1:0]  group_size;
  logic [ValueWidth-1:0] group_buffer [MAX_GROUP];
  logic [CntWidth-1:0]   fill_count;
  logic [CntWidth-1:0]   remain;
  logic [IdxWidth-1:0]   rd_idx;
  logic                  reverse;
  logic                  seq_last;

  logic [CntWidth-1:0]   eff_size;
  logic [CntWidth-1:0]   count_new;
  logic                  full_group;

  // Size zero acts as one; sizes beyond the buffer saturate.
  always_comb begin
    if (group_size == '0) begin
      eff_size = CntWidth'(1);
    end else if (32'(group_size) > 32'(MAX_GROUP)) begin
      eff_size = CntWidth'(MAX_GROUP);
    end else begin
      eff_size = CntWidth'(group_size);
    end
  end

  assign count_new  = CntWidth'(fill_count + 1'b1);
  assign full_group = (count_new >= eff_size);

  assign status.group_done = full_group || end_of_list;
  assign status.final_one  = (remain == CntWidth'(1));
  assign status.out_full   = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      group_size <= SizeReset;
    end else if (cfg_we) begin
      group_size <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write) begin
      group_buffer[fill_count[IdxWidth-1:0]] <= item_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
    end else if (cmd.start) begin
      fill_count <= '0;
    end else if (cmd.write) begin
      fill_count <= count_new;
    end
  end

  // Drain pointer: a full group reads newest first, a remainder oldest first.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      remain   <= count_new;
      reverse  <= full_group;
      seq_last <= end_of_list;
      rd_idx   <= full_group ? fill_count[IdxWidth-1:0] : '0;
    end else if (cmd.emit) begin
      remain <= CntWidth'(remain - 1'b1);
      rd_idx <= reverse ? IdxWidth'(rd_idx - 1'b1) : IdxWidth'(rd_idx + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_value <= group_buffer[rd_idx];
      out_last  <= seq_last && status.final_one;
    end
  end

endmodule

`default_nettype wire

@@ hdl/block_group_reverser_core.sv @@
// ----------------------------------------------------------------------------
// block_group_reverser_core: reverses a value stream in groups
// Collects values into groups of a programmable size and sends each full
// group out newest first; a remainder at the end of a sequence goes out in
// arrival order.
//
//   Channel   Handshake               Payload
//   -------   ---------------------   ---------------------------
//   input     in_valid / in_stall     item_value, end_of_list
//   output    out_valid / out_stall   out_value, out_last
//   config    cfg_we                  cfg_wdata (group_size)
//
// Input items are taken one per cycle while the block fills a group. When
// an item completes a group, or ends the sequence, the input is stalled and
// the n buffered values are sent one per cycle unless the output stalls;
// with the single group buffer, no item is taken until the drain ends. A
// stall on the output holds the result in the output register and pauses the
// drain. Reset is synchronous and active high: it empties the buffer and sets
// the group size to four. The buffer contents themselves are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module block_group_reverser_core #(
  parameter int unsigned MAX_GROUP = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  cfg_we,
  input  wire logic [bgr_pkg::SizeWidth-1:0]         cfg_wdata,
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic signed [bgr_pkg::ValueWidth-1:0] item_value,
  input  wire logic                                  end_of_list,
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic signed [bgr_pkg::ValueWidth-1:0]      out_value,
  output logic                                       out_last
);
  import bgr_pkg::*;

  bgr_cmd_t    cmd;
  bgr_status_t status;

  // The controller decides when to fill and when to drain.
  bgr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // The datapath owns all data storage, including the output register.
  bgr_datapath #(
    .MAX_GROUP (MAX_GROUP)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .item_value  (item_value),
    .end_of_list (end_of_list),
    .out_stall   (out_stall),
    .cmd         (cmd),
    .status      (status),
    .out_valid   (out_valid),
    .out_value   (out_value),
    .out_last    (out_last)
  );

endmodule

`default_nettype wire

@@ dv/block_group_reverser_core_tb.sv @@
// ----------------------------------------------------------------------------
// block_group_reverser_core_tb: self-checking bench for the group reverser
// Drives value sequences through the input channel and predicts every output
// item: full groups come back newest first and a short remainder at the end
// of a sequence comes back in arrival order. The group size register is
// rewritten between phases (zero, saturating values and mid-group changes
// among them) while both channels idle and stall at random.
// ----------------------------------------------------------------------------

module block_group_reverser_core_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import bgr_pkg::*;

  localparam int unsigned GroupDepth = 16;
  // Cycles without any accepted item before the run is declared hung.
  localparam int unsigned HangLimit  = 2000;
  // Cycles allowed after the last result for a drain that produces nothing.
  localparam int unsigned SettleCycles = 6;

  typedef logic signed [ValueWidth-1:0] value_t;

  // One output item as the block should send it.
  typedef struct packed {
    value_t value;
    logic   last;
  } reordered_t;

  // Scoreboard: keeps its own copy of the group buffer and the size register
  // and turns each accepted input item into the output items it releases.
  class group_reversal_board;
    value_t               held [GroupDepth];
    int unsigned          held_count;
    logic [SizeWidth-1:0] size_reg;
    reordered_t           reordered_q [$];
    int unsigned          elements_in;
    int unsigned          results_out;
    int unsigned          mismatches;

    function new();
      size_reg    = SizeReset;
      held_count  = 0;
      elements_in = 0;
      results_out = 0;
      mismatches  = 0;
    endfunction

    function void set_size(logic [SizeWidth-1:0] s);
      size_reg = s;
    endfunction

    // A size of zero acts as one; anything above the buffer depth saturates.
    function int unsigned group_len();
      if (size_reg == '0) return 1;
      if (size_reg > GroupDepth) return GroupDepth;
      return 32'(size_reg);
    endfunction

    function int unsigned pending();
      return reordered_q.size();
    endfunction

    function void take_element(value_t v, logic eol);
      int unsigned k;
      int unsigned n;
      k = group_len();
      elements_in++;
      if (held_count >= GroupDepth) held_count = GroupDepth - 1;
      held[held_count] = v;
      held_count++;
      n = held_count;
      if (n >= k) begin
        // Group complete: newest first, and the oldest one closes a sequence.
        for (int unsigned i = 0; i < n; i++)
          reordered_q.push_back('{held[n-1-i], eol && (i == n - 1)});
        held_count = 0;
      end else if (eol) begin
        // Short remainder at the end of a sequence keeps arrival order.
        for (int unsigned i = 0; i < n; i++)
          reordered_q.push_back('{held[i], i == n - 1});
        held_count = 0;
      end
    endfunction

    function void check_output(value_t v, logic last);
      reordered_t want;
      results_out++;
      if (reordered_q.size() == 0) begin
        $error("out item with none due: out_value %0d out_last %0b", v, last);
        mismatches++;
        return;
      end
      want = reordered_q.pop_front();
      if (v !== want.value) begin
        $error("out_value: expected %0d, actual %0d", want.value, v);
        mismatches++;
      end
      if (last !== want.last) begin
        $error("out_last: expected %0b, actual %0b", want.last, last);
        mismatches++;
      end
    endfunction
  endclass

  logic                 clk         = 1'b0;
  logic                 rst         = 1'b1;
  logic                 cfg_we      = 1'b0;
  logic [SizeWidth-1:0] cfg_wdata   = '0;
  logic                 in_valid    = 1'b0;
  logic                 in_stall;
  value_t               item_value  = '0;
  logic                 end_of_list = 1'b0;
  logic                 out_valid;
  logic                 out_stall   = 1'b0;
  value_t               out_value;
  logic                 out_last;

  group_reversal_board board = new();

  // Percent chance per cycle that the sender holds back or the receiver
  // stalls; the main sequence changes these between phases.
  int unsigned send_idle_pct = 0;
  int unsigned take_idle_pct = 0;
  logic [31:0] sizes_written = '0;
  int unsigned hang_count    = 0;

  block_group_reverser_core #(
    .MAX_GROUP(GroupDepth)
  ) i_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .item_value (item_value),
    .end_of_list(end_of_list),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_value  (out_value),
    .out_last   (out_last)
  );

  always #1 clk = ~clk;

  // Receiver side. Signals read right after the edge still hold the values
  // the block saw at that edge, so an item counts as taken when valid was
  // high and our stall was low. The stall for the next edge is drawn here.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) board.check_output(out_value, out_last);
    out_stall <= ($urandom_range(99) < take_idle_pct);
  end

  // Hang detector: any accepted item on either channel restarts the count.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      hang_count <= 0;
    end else if (hang_count >= HangLimit) begin
      $display("FAIL");
      $finish;
    end else begin
      hang_count <= hang_count + 1;
    end
  end

  // Mostly random values, with the extremes of the signed range mixed in.
  function automatic value_t pick_value();
    case ($urandom_range(9))
      0:       return 32'sh7fff_ffff;
      1:       return 32'sh8000_0000;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Offers one item, possibly after a random gap, and holds it until taken.
  // Called at a rising edge; returns at the edge where the item was taken.
  // Valid stays high between back-to-back items.
  task automatic send_element(input value_t v, input logic eol);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    item_value  <= v;
    end_of_list <= eol;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.take_element(v, eol);
  endtask

  task automatic send_sequence(input int unsigned len, input bit closed);
    for (int unsigned i = 0; i < len; i++)
      send_element(pick_value(), closed && (i == len - 1));
  endtask

  // Lets the block go quiet: every due result delivered, plus a few cycles in
  // case the last item only added to a group and the block is still busy.
  task automatic settle();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // The register is only ever written while the block is quiet.
  task automatic write_group_size(input logic [SizeWidth-1:0] s);
    cfg_we    <= 1'b1;
    cfg_wdata <= s;
    @(posedge clk);
    cfg_we    <= 1'b0;
    board.set_size(s);
    sizes_written[s] = 1'b1;
  endtask

  // Register settings for the random chunks: the pass-through and widest
  // sizes, zero, values past the buffer depth, and ordinary sizes between.
  int unsigned size_plan [12] = '{1, 16, 0, 31, 17, 2, 3, 5, 7, 8, 11, 15};

  initial begin
    int unsigned chunk_items;
    int unsigned len;
    int unsigned k;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // First phase of idling: sender rarely idles, receiver often stalls.
    send_idle_pct = 15;
    take_idle_pct = 54;

    // Reset size of four: a full group that also ends the sequence, so the
    // end flag goes onto the oldest value, sent last. Field extremes here.
    send_element(32'sh7fff_ffff, 1'b0);
    send_element(32'sh8000_0000, 1'b0);
    send_element('0, 1'b0);
    send_element('1, 1'b1);
    // A remainder shorter than the group keeps its order.
    send_element(32'sh1234_5678, 1'b0);
    send_element(-32'sd5, 1'b1);
    settle();

    // Size lowered with three values already buffered: the next item makes
    // the count pass the new size, so all four leave as one reversed group.
    send_sequence(3, 1'b0);
    settle();
    write_group_size(5'd2);
    send_element(pick_value(), 1'b0);
    send_element(pick_value(), 1'b1);
    settle();

    // Size zero behaves as pass-through.
    write_group_size(5'd0);
    send_sequence(2, 1'b1);
    settle();

    // Largest code saturates to the buffer depth; eight values are only a
    // remainder then.
    write_group_size(5'd31);
    send_sequence(8, 1'b1);
    settle();

    // Random part: three idling phases, four register settings each. Most
    // sequences are closed; an open one runs on into the next one, or past the
    // chunk's end into the next setting, exercising a partly filled group.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 15;
          take_idle_pct = 54;
        end
        1: begin
          send_idle_pct = 54;
          take_idle_pct = 15;
        end
        default: begin
          send_idle_pct = 0;
          take_idle_pct = 0;
        end
      endcase
      for (int c = 0; c < 4; c++) begin
        write_group_size(SizeWidth'(size_plan[phase * 4 + c]));
        k = board.group_len();
        chunk_items = 0;
        while (chunk_items < 27) begin
          len = $urandom_range(1, 2 * k + 2);
          send_sequence(len, $urandom_range(9) != 0);
          chunk_items += len;
        end
        settle();
      end
    end

    // Wait out anything still draining; the hang detector bounds this.
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (4 * GroupDepth) @(posedge clk);

    $display("Covered %0d input items and %0d output items; group sizes written: %b",
             board.elements_in, board.results_out, sizes_written);
    $display("Sizes include zero, pass-through, full depth, saturation and a mid-group cut.");
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/bgr_pkg.sv
hdl/bgr_ctrl.sv
hdl/bgr_datapath.sv
hdl/block_group_reverser_core.sv
dv/block_group_reverser_core_tb.sv
